// ===== design/kst_pkg.sv =====
// kst_pkg: shared types, codes and the arrow key table for the key state tracker
// depends on nothing; used by kst_decode and the tracker top by scoped names
`default_nettype none

package kst_pkg;

  // input item modes
  localparam logic [1:0] MODE_SCAN  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_ARROW = 2'd2;

  // reported key status
  localparam logic [1:0] STATUS_UP       = 2'd0;
  localparam logic [1:0] STATUS_DOWN     = 2'd1;
  localparam logic [1:0] STATUS_PRESSED  = 2'd2;
  localparam logic [1:0] STATUS_RELEASED = 2'd3;

  // scan byte prefixes and fields
  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_SKIP1 = 8'hE1;
  localparam logic [7:0] BYTE_SKIP2 = 8'hE2;

  // extended table codes of the arrows
  localparam logic [6:0] CODE_RIGHT = 7'd77;
  localparam logic [6:0] CODE_UP    = 7'd72;
  localparam logic [6:0] CODE_LEFT  = 7'd75;
  localparam logic [6:0] CODE_DOWN  = 7'd80;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_QUERY,
    OP_REPORT_UP
  } kst_op_e;

  // decoded request handed to the table stage
  typedef struct packed {
    kst_op_e    op;
    logic       ext;
    logic [6:0] code;
    logic       level;
  } kst_req_t;

  function automatic logic [6:0] arrow_code(input logic [1:0] dir);
    logic [6:0] c;
    c = CODE_RIGHT;
    unique case (dir)
      DIR_RIGHT: c = CODE_RIGHT;
      DIR_UP:    c = CODE_UP;
      DIR_LEFT:  c = CODE_LEFT;
      DIR_DOWN:  c = CODE_DOWN;
      default:   c = CODE_RIGHT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/kst_decode.sv =====
// kst_decode: prefix tracking and decoding of one input item into a table request
// depends on kst_pkg
`default_nettype none

module kst_decode #(
  parameter int KEY_SLOTS = 96
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [7:0]        scan_byte_i,
  input  wire logic [7:0]        key_index_i,
  input  wire logic [2:0]        direction_i,
  output kst_pkg::kst_req_t      req_o
);

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_EXT,
    PFX_SKIP
  } prefix_e;

  localparam logic [8:0] Slots = 9'(KEY_SLOTS);

  prefix_e prefix_q, prefix_d;
  logic [6:0] arrow;
  logic       scan_in_range;

  assign arrow         = kst_pkg::arrow_code(direction_i[1:0]);
  assign scan_in_range = {2'b00, scan_byte_i[6:0]} < Slots;

  always_comb begin
    prefix_d    = prefix_q;
    req_o.op    = kst_pkg::OP_NONE;
    req_o.ext   = 1'b0;
    req_o.code  = '0;
    req_o.level = ~scan_byte_i[7];
    case (mode_i)
      kst_pkg::MODE_SCAN: begin
        prefix_d = PFX_NONE;
        if (prefix_q == PFX_EXT) begin
          // byte after e0 goes to the extended table when its code is in range
          if (scan_in_range) begin
            req_o.op   = kst_pkg::OP_UPDATE;
            req_o.ext  = 1'b1;
            req_o.code = scan_byte_i[6:0];
          end
        end else if (prefix_q == PFX_SKIP) begin
          prefix_d = PFX_NONE;
        end else if (scan_byte_i == kst_pkg::BYTE_EXT) begin
          prefix_d = PFX_EXT;
        end else if (scan_byte_i == kst_pkg::BYTE_SKIP1 ||
                     scan_byte_i == kst_pkg::BYTE_SKIP2) begin
          prefix_d = PFX_SKIP;
        end else if (scan_in_range) begin
          req_o.op   = kst_pkg::OP_UPDATE;
          req_o.code = scan_byte_i[6:0];
        end
      end
      kst_pkg::MODE_QUERY: begin
        if ({1'b0, key_index_i} < Slots) begin
          req_o.op   = kst_pkg::OP_QUERY;
          req_o.code = key_index_i[6:0];
        end else begin
          req_o.op = kst_pkg::OP_REPORT_UP;
        end
      end
      kst_pkg::MODE_ARROW: begin
        if (!direction_i[2] && ({2'b00, arrow} < Slots)) begin
          req_o.op   = kst_pkg::OP_QUERY;
          req_o.ext  = 1'b1;
          req_o.code = arrow;
        end else begin
          req_o.op = kst_pkg::OP_REPORT_UP;
        end
      end
      default: begin
        req_o.op = kst_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PFX_NONE;
    end else if (accept_i) begin
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/kst_key_ram.sv =====
// kst_key_ram: key table memory, one entry of down and read bits per key
// registered read, per-entry valid bits so unwritten entries read as zero
`default_nettype none

module kst_key_ram #(
  parameter int Depth = 192,
  parameter int AddrW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [1:0]       wr_data_i,
  output logic      [1:0]       rd_data_o
);

  logic [1:0]       mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [1:0]       rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : 2'b00;

endmodule

`default_nettype wire

// ===== design/keyboard_scancode_key_state_tracker.sv =====
// keyboard_scancode_key_state_tracker: set-1 scan byte decoder and key state table
// a query's status passes the table stage, which reads the key ram, then the output register
// one item per cycle unless the output stalls, set by the single read-modify-write pass
// reset: prefix cleared, all keys up and unread at once through per-entry valid bits
// depends on kst_pkg, kst_decode and kst_key_ram
`default_nettype none

module keyboard_scancode_key_state_tracker #(
  parameter int KEY_SLOTS = 96
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] scan_byte_i,
  input  wire logic [7:0] key_index_i,
  input  wire logic [2:0] direction_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      key_status_o
);

  // normal table in the low half of the ram, extended table above it
  localparam int Depth = 2 * KEY_SLOTS;
  localparam int AddrW = $clog2(Depth);

  kst_pkg::kst_req_t req;
  logic              accept;
  logic [AddrW-1:0]  rd_addr;

  // table stage: holds the item whose ram read is in flight
  logic              s1_valid_q, s1_valid_d;
  kst_pkg::kst_op_e  s1_op_q;
  logic              s1_level_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic              s1_has_out;
  logic              s1_adv;

  // last write, covers a read taken at the same edge as the write
  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [1:0]        fwd_data_q;

  logic [1:0]        ram_rd;
  logic [1:0]        cur;       // [1] down, [0] read flag
  logic [1:0]        new_entry;
  logic [1:0]        status;
  logic              ram_we;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        key_status_q, key_status_d;

  assign accept = in_valid_i && in_ready_o;

  kst_decode #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .scan_byte_i (scan_byte_i),
    .key_index_i (key_index_i),
    .direction_i (direction_i),
    .req_o       (req)
  );

  // code is zero unless in range, so the address always lands inside the ram
  assign rd_addr = req.ext ? (AddrW'(req.code) + AddrW'(KEY_SLOTS)) : AddrW'(req.code);

  kst_key_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .we_i      (ram_we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_entry),
    .rd_data_o (ram_rd)
  );

  // queries need the output slot, table updates never wait for it
  assign s1_has_out = (s1_op_q == kst_pkg::OP_QUERY) || (s1_op_q == kst_pkg::OP_REPORT_UP);
  assign s1_adv     = !s1_has_out || !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign cur = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rd;

  always_comb begin
    new_entry = cur;
    status    = kst_pkg::STATUS_UP;
    unique case (s1_op_q)
      kst_pkg::OP_UPDATE: begin
        // a change of level marks the key unread
        if (cur[1] != s1_level_q) begin
          new_entry = {s1_level_q, 1'b0};
        end
      end
      kst_pkg::OP_QUERY: begin
        if (cur[1]) begin
          status = cur[0] ? kst_pkg::STATUS_DOWN : kst_pkg::STATUS_PRESSED;
        end else begin
          status = cur[0] ? kst_pkg::STATUS_UP : kst_pkg::STATUS_RELEASED;
        end
        new_entry = {cur[1], 1'b1};
      end
      kst_pkg::OP_REPORT_UP: begin
        status = kst_pkg::STATUS_UP;
      end
      default: begin
        new_entry = cur;
      end
    endcase
  end

  assign ram_we = s1_valid_q && s1_adv &&
                  ((s1_op_q == kst_pkg::OP_UPDATE) || (s1_op_q == kst_pkg::OP_QUERY));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    key_status_d = key_status_q;
    if (s1_valid_q && s1_has_out && s1_adv) begin
      out_valid_d  = 1'b1;
      key_status_d = status;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= req.op;
      s1_level_q <= req.level;
      s1_addr_q  <= rd_addr;
    end
    if (ram_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_entry;
    end
    key_status_q <= key_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign key_status_o = key_status_q;

  // input stalls only when both the table stage and the output slot are full
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // a query always leaves its key marked read
  a_query_marks_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (s1_op_q == kst_pkg::OP_QUERY)) |-> new_entry[0])
    else $error("query did not set the read flag");

  // an update leaves the key at the level of its scan byte
  a_update_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (s1_op_q == kst_pkg::OP_UPDATE)) |-> (new_entry[1] == s1_level_q))
    else $error("update wrote the wrong level");

  // the forwarding register follows every write
  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (fwd_valid_q && (fwd_addr_q == $past(s1_addr_q))
                && (fwd_data_q == $past(new_entry))))
    else $error("forwarding register missed a write");

  // a result is loaded only when the slot is free or being emptied
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(key_status_q) && out_valid_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== test/kst_status_checker.sv =====
// kst_status_checker: watches both channels of the key state tracker, predicts key status
// from its own copy of the prefix state and key tables, and counts mismatches
// depends on kst_pkg for mode, status, prefix and arrow code constants
`timescale 1ns / 100ps

module kst_status_checker #(
  parameter int KEY_SLOTS = 96
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] scan_byte_i,
  input  wire logic [7:0] key_index_i,
  input  wire logic [2:0] direction_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [1:0] key_status_i,
  output int              fail_count_o,
  output int              due_count_o
);

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_EXT,
    HOLD_SKIP
  } hold_e;

  hold_e                prefix_q;
  logic [KEY_SLOTS-1:0] norm_down;
  logic [KEY_SLOTS-1:0] norm_seen;
  logic [KEY_SLOTS-1:0] ext_down;
  logic [KEY_SLOTS-1:0] ext_seen;
  logic [1:0]           status_due[$];
  logic [1:0]           want;
  int                   fails;

  // a change of level marks the key unread
  function automatic void set_key_level(input logic ext, input logic [6:0] code,
                                        input logic level);
    if (code >= KEY_SLOTS) return;
    if (ext) begin
      if (ext_down[code] != level) begin
        ext_down[code] = level;
        ext_seen[code] = 1'b0;
      end
    end else begin
      if (norm_down[code] != level) begin
        norm_down[code] = level;
        norm_seen[code] = 1'b0;
      end
    end
  endfunction

  function automatic logic [1:0] read_key_status(input logic ext, input int code);
    logic is_down;
    logic was_seen;
    if (code >= KEY_SLOTS) return kst_pkg::STATUS_UP;
    is_down  = ext ? ext_down[code] : norm_down[code];
    was_seen = ext ? ext_seen[code] : norm_seen[code];
    if (ext) ext_seen[code] = 1'b1;
    else norm_seen[code] = 1'b1;
    if (is_down) return was_seen ? kst_pkg::STATUS_DOWN : kst_pkg::STATUS_PRESSED;
    return was_seen ? kst_pkg::STATUS_UP : kst_pkg::STATUS_RELEASED;
  endfunction

  function automatic void track_item(input logic [1:0] mode, input logic [7:0] sb,
                                     input logic [7:0] kidx, input logic [2:0] dir);
    logic [6:0] arrow;
    arrow = kst_pkg::CODE_RIGHT;
    case (mode)
      kst_pkg::MODE_SCAN: begin
        case (prefix_q)
          HOLD_EXT: begin
            // whatever follows E0 is an extended key byte, prefixes too
            set_key_level(1'b1, sb[6:0], !sb[7]);
            prefix_q = HOLD_NONE;
          end
          HOLD_SKIP: prefix_q = HOLD_NONE;
          default: begin
            if (sb == kst_pkg::BYTE_EXT) prefix_q = HOLD_EXT;
            else if (sb == kst_pkg::BYTE_SKIP1 || sb == kst_pkg::BYTE_SKIP2)
              prefix_q = HOLD_SKIP;
            else begin
              prefix_q = HOLD_NONE;
              set_key_level(1'b0, sb[6:0], !sb[7]);
            end
          end
        endcase
      end
      kst_pkg::MODE_QUERY: status_due.push_back(read_key_status(1'b0, kidx));
      kst_pkg::MODE_ARROW: begin
        if (dir[2]) begin
          status_due.push_back(kst_pkg::STATUS_UP);
        end else begin
          case (dir[1:0])
            kst_pkg::DIR_RIGHT: arrow = kst_pkg::CODE_RIGHT;
            kst_pkg::DIR_UP:    arrow = kst_pkg::CODE_UP;
            kst_pkg::DIR_LEFT:  arrow = kst_pkg::CODE_LEFT;
            default:            arrow = kst_pkg::CODE_DOWN;
          endcase
          status_due.push_back(read_key_status(1'b1, arrow));
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  = HOLD_NONE;
      norm_down = '0;
      norm_seen = '0;
      ext_down  = '0;
      ext_seen  = '0;
      fails     = 0;
      status_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (status_due.size() == 0) begin
          fails++;
          $display("%0t: key status %0d with no query outstanding", $time, key_status_i);
        end else begin
          want = status_due.pop_front();
          if (key_status_i !== want) begin
            fails++;
            $display("%0t: key status expected %0d actual %0d", $time, want, key_status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) track_item(mode_i, scan_byte_i, key_index_i, direction_i);
    end
    fail_count_o <= fails;
    due_count_o  <= status_due.size();
  end

endmodule

// ===== test/keyboard_scancode_key_state_tracker_test.sv =====
// keyboard_scancode_key_state_tracker_test: drives scan bytes and key queries into the
// tracker with random gaps and output stalls; kst_status_checker predicts and compares
// depends on kst_pkg, keyboard_scancode_key_state_tracker and kst_status_checker
`timescale 1ns / 100ps

module keyboard_scancode_key_state_tracker_test;

  localparam int         KEY_SLOTS    = 96;
  localparam int         ITEM_TARGET  = 650;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         SETTLE_TICKS = 12;
  // mode 3 is not decoded by the block, it is swallowed without a result
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [7:0] scan_byte;
  logic [7:0] key_index;
  logic [2:0] direction;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] key_status;
  int         fail_count;
  int         due_count;

  // set while a stretch runs with no gaps and no stalls
  logic       calm;
  int         sent;

  keyboard_scancode_key_state_tracker #(
    .KEY_SLOTS(KEY_SLOTS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .scan_byte_i (scan_byte),
    .key_index_i (key_index),
    .direction_i (direction),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_status_o(key_status)
  );

  kst_status_checker #(
    .KEY_SLOTS(KEY_SLOTS)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .mode_i      (mode),
    .scan_byte_i (scan_byte),
    .key_index_i (key_index),
    .direction_i (direction),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .key_status_i(key_status),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one item: optional idle gap with valid low, then hold valid until the handshake
  task automatic push_item(input logic [1:0] m, input logic [7:0] sb,
                           input logic [7:0] ki, input logic [2:0] dr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    scan_byte <= sb;
    key_index <= ki;
    direction <= dr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m != MODE_IGNORED) sent++;
  endtask

  // scan byte with junk in the unused fields
  task automatic scan_item(input logic [7:0] sb);
    push_item(kst_pkg::MODE_SCAN, sb, 8'($urandom), 3'($urandom));
  endtask

  task automatic query_item(input logic [7:0] ki);
    push_item(kst_pkg::MODE_QUERY, 8'($urandom), ki, 3'($urandom));
  endtask

  task automatic arrow_item(input logic [2:0] dr);
    push_item(kst_pkg::MODE_ARROW, 8'($urandom), 8'($urandom), dr);
  endtask

  // hold the sender off until every query has been answered
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
  endtask

  function automatic logic [6:0] arrow_code_of(input int pick);
    case (pick)
      0:       return kst_pkg::CODE_RIGHT;
      1:       return kst_pkg::CODE_UP;
      2:       return kst_pkg::CODE_LEFT;
      default: return kst_pkg::CODE_DOWN;
    endcase
  endfunction

  // receiver: each result waits a random stall, ready stays up until it is taken
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog: too long without any handshake means the block has hung
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int         pick;
    int         round;
    logic [6:0] code;
    logic [7:0] ki;
    in_valid  = 1'b0;
    mode      = kst_pkg::MODE_SCAN;
    scan_byte = '0;
    key_index = '0;
    direction = '0;
    calm      = 1'b0;
    sent      = 0;
    round     = 0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset state reads as an unread release, then up
    query_item(8'd0);
    query_item(8'd0);
    // make of the lowest key, first read pressed then down
    scan_item(8'h00);
    query_item(8'd0);
    query_item(8'd0);
    // make and break of the highest key before any read
    scan_item(8'(KEY_SLOTS - 1));
    scan_item(8'h80 | 8'(KEY_SLOTS - 1));
    query_item(8'(KEY_SLOTS - 1));
    // codes past the table change nothing
    scan_item(8'(KEY_SLOTS));
    scan_item(8'hFF);
    query_item(8'(KEY_SLOTS));
    query_item(8'hFF);
    // extended make of the right arrow
    scan_item(kst_pkg::BYTE_EXT);
    scan_item({1'b0, kst_pkg::CODE_RIGHT});
    arrow_item(3'd0);
    // directions past the four arrows read as up
    arrow_item(3'd4);
    arrow_item(3'd7);
    // a prefix right after E0 is an extended byte, here out of the table
    scan_item(kst_pkg::BYTE_EXT);
    scan_item(kst_pkg::BYTE_EXT);
    // bytes after E1 and E2 are thrown away
    scan_item(kst_pkg::BYTE_SKIP1);
    scan_item(8'h1D);
    scan_item(kst_pkg::BYTE_SKIP2);
    scan_item(8'h9D);
    query_item(8'h1D);
    // unused mode, no result
    push_item(MODE_IGNORED, 8'($urandom), 8'($urandom), 3'($urandom));
    // extended break of the up arrow, then the up, left and down arrows
    scan_item(kst_pkg::BYTE_EXT);
    scan_item({1'b1, kst_pkg::CODE_UP});
    arrow_item(3'd1);
    arrow_item(3'd2);
    arrow_item(3'd3);
    drain();

    // random: mostly well-formed scan sequences and queries on a few hot keys
    while (sent < ITEM_TARGET) begin
      if (round % 80 == 0) calm = ($urandom_range(0, 3) == 0);
      round++;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        code = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 11))
                                           : 7'($urandom_range(0, 127));
        scan_item({1'($urandom_range(0, 1)), code});
      end else if (pick < 45) begin
        code = ($urandom_range(0, 9) < 7) ? arrow_code_of($urandom_range(0, 3))
                                          : 7'($urandom_range(0, 127));
        scan_item(kst_pkg::BYTE_EXT);
        scan_item({1'($urandom_range(0, 1)), code});
      end else if (pick < 50) begin
        scan_item($urandom_range(0, 1) ? kst_pkg::BYTE_SKIP1 : kst_pkg::BYTE_SKIP2);
        scan_item(8'($urandom));
      end else if (pick < 72) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ki = 8'($urandom_range(0, 11));
          6, 7, 8:          ki = 8'($urandom_range(0, KEY_SLOTS - 1));
          default:          ki = 8'($urandom);
        endcase
        query_item(ki);
      end else if (pick < 90) begin
        arrow_item(($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, 3)) : 3'($urandom));
      end else begin
        // noise: anything at all, the unused mode included
        push_item(2'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
      end
      if ($urandom_range(0, 59) == 0) drain();
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/kst_pkg.sv
design/kst_decode.sv
design/kst_key_ram.sv
design/keyboard_scancode_key_state_tracker.sv
test/kst_status_checker.sv
test/keyboard_scancode_key_state_tracker_test.sv
